### sv/ffba_pkg.sv
// Shared constants and types of the first-fit block allocator.
package ffba_pkg;
  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int LNK_W = IDX_W + 1;
  localparam int CNT_W = 11;
  localparam int STAT_W = 2;
  localparam int STEP_W = IDX_W + 1;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic [LNK_W-1:0] len;
    logic [LNK_W-1:0] nxt;
    logic [LNK_W-1:0] prv;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;
endpackage

### sv/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator with coalescing.
// Each request is a word on in_*, taken at a rising edge where start is high
// and busy is low. The block keeps the free extents in address order as a
// doubly linked list in one table memory (length, next link, prev link per
// block, registered read); links are block index + 1, zero is null.
// Each step does at most one read or one write of that table, so no two
// accesses overlap. An allocate walks the list from the head, reading each
// extent in turn; when one fits, it writes the remainder (if the extent was
// longer), patches the neighbors that are present and its own entry, and
// then shows its result word. An allocate that finds no fit before the end
// of the list answers with a no-fit status. A free walks to its place in
// address order, links in and then coalesces with its successor and, when
// it has one, merges its predecessor with it; then its result shows.
// Zero-count allocates, allocates on an empty list and out-of-range frees
// answer directly from idle. Every walk stops after NUM_BLOCKS extents.
// Busy stays high until the result cycle is over, so the next word is taken
// no earlier than the cycle after it. After reset the S_INIT state writes
// entry 0 as the whole heap, with busy high; no other entry is cleared, so
// only a block that was once granted may be freed. Each result shows on
// out_status/out_start_block for exactly one cycle with out_valid high; the
// receiver cannot stall it.
module first_fit_block_allocator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [ffba_pkg::CNT_W-1:0]   in_block_count,
  input  logic [ffba_pkg::CNT_W-1:0]   in_block_index,
  output logic                         out_valid,
  output logic [ffba_pkg::STAT_W-1:0]  out_status,
  output logic [ffba_pkg::IDX_W-1:0]   out_start_block
);
  import ffba_pkg::*;

  typedef enum logic [26:0] {
    S_INIT = 27'h0000001,  // write entry 0 as the whole heap
    S_IDLE = 27'h0000002,
    S_ARD  = 27'h0000004,  // alloc: read current extent
    S_AEV  = 27'h0000008,  // alloc: fit or advance
    S_ASPL = 27'h0000010,  // alloc: write remainder
    S_APRD = 27'h0000020,  // alloc: read predecessor
    S_APWR = 27'h0000040,  // alloc: patch predecessor next link
    S_ANRD = 27'h0000080,  // alloc: read successor
    S_ANWR = 27'h0000100,  // alloc: patch successor back link
    S_AOWN = 27'h0000200,  // alloc: write granted entry
    S_FRD  = 27'h0000400,  // free: read walk entry
    S_FEV  = 27'h0000800,  // free: advance or stop
    S_FORD = 27'h0001000,  // free: read own entry
    S_FOSV = 27'h0002000,  // free: hold own entry, read predecessor
    S_FPNX = 27'h0004000,  // free: take predecessor's next link
    S_FOWR = 27'h0008000,  // free: write own links
    S_FNRD = 27'h0010000,  // free: read successor
    S_FNWR = 27'h0020000,  // free: patch successor back link
    S_FPRD = 27'h0040000,  // free: read predecessor
    S_FPWR = 27'h0080000,  // free: patch predecessor next link
    S_MRD  = 27'h0100000,  // merge: read base entry
    S_MEV  = 27'h0200000,  // merge: adjacent? read successor
    S_MWR  = 27'h0400000,  // merge: write grown base entry
    S_MNRD = 27'h0800000,  // merge: read new successor
    S_MNWR = 27'h1000000,  // merge: patch its back link
    S_MEND = 27'h2000000,  // merge: next pass or finish
    S_DONE = 27'h4000000
  } state_t;

  state_t            st_r, st_nxt;
  mem_req_t          mreq;
  entry_t            rd;
  logic [LNK_W-1:0]  head_r, head_nxt;
  logic [LNK_W-1:0]  cur_r, cur_nxt;       // walk link, then predecessor link
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  blk_r, blk_nxt;       // block under operation
  entry_t            ent_r, ent_nxt;       // saved entry of blk_r
  logic [LNK_W-1:0]  nbr_r, nbr_nxt;       // successor link to patch
  logic              pass_r, pass_nxt;     // second merge pass
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [IDX_W-1:0]  sb_r, sb_nxt;

  logic              split;
  logic [IDX_W-1:0]  rem_idx;
  logic [LNK_W-1:0]  rem_lnk;
  logic [LNK_W-1:0]  pred_lnk;             // new next link of predecessor
  logic [LNK_W-1:0]  succ_lnk;             // new back link of successor
  logic [LNK_W:0]    ext_end;              // base + its length

  ffba_ram u_ram (.clk(clk), .req(mreq), .rdata(rd));

  function automatic logic [IDX_W-1:0] ix(input logic [LNK_W-1:0] l);
    logic [LNK_W-1:0] t;
    t = l - 1'b1;
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [LNK_W-1:0] lk(input logic [IDX_W-1:0] i);
    return {1'b0, i} + 1'b1;
  endfunction

  // capped merged length: min(a+b, NUM_BLOCKS - base)
  function automatic logic [LNK_W-1:0] mlen(input logic [LNK_W-1:0] a,
                                            input logic [LNK_W-1:0] b,
                                            input logic [IDX_W-1:0] base);
    logic [LNK_W:0] sum, room;
    sum  = {1'b0, a} + {1'b0, b};
    room = (LNK_W+1)'(NUM_BLOCKS) - {2'b0, base};
    return (sum < room) ? sum[LNK_W-1:0] : room[LNK_W-1:0];
  endfunction

  // Split when the chosen extent is longer than the request; the remainder
  // then takes the extent's place in the list.
  assign split    = ent_r.len > cnt_r;
  assign rem_idx  = blk_r + cnt_r[IDX_W-1:0];
  assign rem_lnk  = lk(rem_idx);
  assign pred_lnk = split ? rem_lnk : ent_r.nxt;
  assign succ_lnk = split ? rem_lnk : ent_r.prv;
  assign ext_end  = {2'b0, blk_r} + {1'b0, rd.len};

  always_comb begin
    st_nxt = st_r; head_nxt = head_r; cur_nxt = cur_r; steps_nxt = steps_r;
    cnt_nxt = cnt_r; blk_nxt = blk_r; ent_nxt = ent_r; nbr_nxt = nbr_r;
    pass_nxt = pass_r; stat_nxt = stat_r; sb_nxt = sb_r;
    mreq = '0;
    case (st_r)
      S_INIT: begin
        mreq.we = 1'b1;
        mreq.waddr = '0;
        mreq.wdata.len = LNK_W'(NUM_BLOCKS);
        st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cnt_nxt = in_block_count;
          blk_nxt = in_block_index[IDX_W-1:0];
          cur_nxt = head_r;
          steps_nxt = '0;
          pass_nxt = 1'b0;
          stat_nxt = ST_OK;
          sb_nxt = '0;
          if (in_req_type == REQ_ALLOC) begin
            if (in_block_count == '0 || head_r == '0) begin
              stat_nxt = ST_NOFIT; st_nxt = S_DONE;
            end else begin
              st_nxt = S_ARD;
            end
          end else if (in_block_index >= CNT_W'(NUM_BLOCKS)) begin
            stat_nxt = ST_RANGE; st_nxt = S_DONE;
          end else if (head_r != '0 && in_block_index[IDX_W-1:0] > ix(head_r)) begin
            st_nxt = S_FRD;
          end else begin
            cur_nxt = '0; st_nxt = S_FORD;
          end
        end
      end
      // ---------------- allocate ----------------
      S_ARD: begin
        mreq.re = 1'b1; mreq.raddr = ix(cur_r); st_nxt = S_AEV;
      end
      S_AEV: begin
        if (rd.len >= cnt_r) begin
          blk_nxt = ix(cur_r);
          ent_nxt = rd;
          st_nxt = S_ASPL;
        end else begin
          steps_nxt = steps_r + 1'b1;
          cur_nxt = rd.nxt;
          if (rd.nxt == '0 || steps_r + 1'b1 >= STEP_W'(NUM_BLOCKS)) begin
            stat_nxt = ST_NOFIT; st_nxt = S_DONE;
          end else begin
            st_nxt = S_ARD;
          end
        end
      end
      S_ASPL: begin
        if (split) begin
          mreq.we = 1'b1; mreq.waddr = rem_idx;
          mreq.wdata.len = ent_r.len - cnt_r;
          mreq.wdata.nxt = ent_r.nxt;
          mreq.wdata.prv = ent_r.prv;
        end
        st_nxt = S_APRD;
      end
      S_APRD: begin
        if (ent_r.prv != '0) begin
          mreq.re = 1'b1; mreq.raddr = ix(ent_r.prv); st_nxt = S_APWR;
        end else begin
          head_nxt = pred_lnk; st_nxt = S_ANRD;
        end
      end
      S_APWR: begin
        mreq.we = 1'b1; mreq.waddr = ix(ent_r.prv);
        mreq.wdata = rd; mreq.wdata.nxt = pred_lnk;
        st_nxt = S_ANRD;
      end
      S_ANRD: begin
        if (ent_r.nxt != '0) begin
          mreq.re = 1'b1; mreq.raddr = ix(ent_r.nxt); st_nxt = S_ANWR;
        end else begin
          st_nxt = S_AOWN;
        end
      end
      S_ANWR: begin
        mreq.we = 1'b1; mreq.waddr = ix(ent_r.nxt);
        mreq.wdata = rd; mreq.wdata.prv = succ_lnk;
        st_nxt = S_AOWN;
      end
      S_AOWN: begin
        mreq.we = 1'b1; mreq.waddr = blk_r;
        mreq.wdata.len = cnt_r;
        sb_nxt = blk_r; st_nxt = S_DONE;
      end
      // ---------------- free ----------------
      S_FRD: begin
        mreq.re = 1'b1; mreq.raddr = ix(cur_r); st_nxt = S_FEV;
      end
      S_FEV: begin
        if (rd.nxt != '0 && blk_r > ix(rd.nxt) && steps_r < STEP_W'(NUM_BLOCKS)) begin
          cur_nxt = rd.nxt; steps_nxt = steps_r + 1'b1; st_nxt = S_FRD;
        end else begin
          st_nxt = S_FORD;
        end
      end
      S_FORD: begin
        mreq.re = 1'b1; mreq.raddr = blk_r; st_nxt = S_FOSV;
      end
      S_FOSV: begin
        ent_nxt = rd;
        if (cur_r != '0) begin
          mreq.re = 1'b1; mreq.raddr = ix(cur_r); st_nxt = S_FPNX;
        end else begin
          nbr_nxt = head_r; st_nxt = S_FOWR;
        end
      end
      S_FPNX: begin
        nbr_nxt = rd.nxt; st_nxt = S_FOWR;
      end
      S_FOWR: begin
        mreq.we = 1'b1; mreq.waddr = blk_r;
        mreq.wdata.len = ent_r.len;
        mreq.wdata.nxt = nbr_r;
        mreq.wdata.prv = cur_r;
        st_nxt = S_FNRD;
      end
      S_FNRD: begin
        if (nbr_r != '0) begin
          mreq.re = 1'b1; mreq.raddr = ix(nbr_r); st_nxt = S_FNWR;
        end else begin
          st_nxt = S_FPRD;
        end
      end
      S_FNWR: begin
        mreq.we = 1'b1; mreq.waddr = ix(nbr_r);
        mreq.wdata = rd; mreq.wdata.prv = lk(blk_r);
        st_nxt = S_FPRD;
      end
      S_FPRD: begin
        if (cur_r != '0) begin
          mreq.re = 1'b1; mreq.raddr = ix(cur_r); st_nxt = S_FPWR;
        end else begin
          head_nxt = lk(blk_r); st_nxt = S_MRD;
        end
      end
      S_FPWR: begin
        mreq.we = 1'b1; mreq.waddr = ix(cur_r);
        mreq.wdata = rd; mreq.wdata.nxt = lk(blk_r);
        st_nxt = S_MRD;
      end
      // ---------------- merge blk_r with its successor ----------------
      S_MRD: begin
        mreq.re = 1'b1; mreq.raddr = blk_r; st_nxt = S_MEV;
      end
      S_MEV: begin
        ent_nxt = rd;
        if (rd.nxt != '0 && ext_end == {1'b0, rd.nxt - 1'b1}) begin
          mreq.re = 1'b1; mreq.raddr = ix(rd.nxt); st_nxt = S_MWR;
        end else begin
          st_nxt = S_MEND;
        end
      end
      S_MWR: begin
        mreq.we = 1'b1; mreq.waddr = blk_r;
        mreq.wdata.len = mlen(ent_r.len, rd.len, blk_r);
        mreq.wdata.nxt = rd.nxt;
        mreq.wdata.prv = ent_r.prv;
        nbr_nxt = rd.nxt;
        st_nxt = S_MNRD;
      end
      S_MNRD: begin
        if (nbr_r != '0) begin
          mreq.re = 1'b1; mreq.raddr = ix(nbr_r); st_nxt = S_MNWR;
        end else begin
          st_nxt = S_MEND;
        end
      end
      S_MNWR: begin
        mreq.we = 1'b1; mreq.waddr = ix(nbr_r);
        mreq.wdata = rd; mreq.wdata.prv = lk(blk_r);
        st_nxt = S_MEND;
      end
      S_MEND: begin
        // Merge the predecessor with the freed extent next, if there is one.
        if (!pass_r && cur_r != '0) begin
          pass_nxt = 1'b1; blk_nxt = ix(cur_r); st_nxt = S_MRD;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_INIT;
      head_r  <= LNK_W'(1);
      cur_r   <= '0;
      steps_r <= '0;
      cnt_r   <= '0;
      blk_r   <= '0;
      ent_r   <= '0;
      nbr_r   <= '0;
      pass_r  <= 1'b0;
      stat_r  <= ST_OK;
      sb_r    <= '0;
    end else begin
      st_r    <= st_nxt;
      head_r  <= head_nxt;
      cur_r   <= cur_nxt;
      steps_r <= steps_nxt;
      cnt_r   <= cnt_nxt;
      blk_r   <= blk_nxt;
      ent_r   <= ent_nxt;
      nbr_r   <= nbr_nxt;
      pass_r  <= pass_nxt;
      stat_r  <= stat_nxt;
      sb_r    <= sb_nxt;
    end
  end

  assign busy            = (st_r != S_IDLE);
  assign out_valid       = (st_r == S_DONE);
  assign out_status      = stat_r;
  assign out_start_block = sb_r;
endmodule

### sv/ffba_ram.sv
// Single-port-write, single-port-read table of extent entries.
module ffba_ram (
  input  logic              clk,
  input  ffba_pkg::mem_req_t req,
  output ffba_pkg::entry_t  rdata
);
  import ffba_pkg::*;

  entry_t mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
